>>> rtl/core/mm8_pkg.sv
package mm8_pkg;

    localparam int DIM        = 8;
    localparam int ELEM_WIDTH = 16;

    // fixed field widths
    localparam int ROW_W = 3;
    localparam int OUT_W = 35;

    localparam int IDX_W  = $clog2(DIM);
    localparam int ADDR_W = $clog2(DIM * DIM);
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int EXT_W  = (PROD_W > OUT_W) ? PROD_W : OUT_W;

    // product flowing down the cell chain, tagged with its target column
    typedef struct packed {
        logic                    vld;
        logic [IDX_W-1:0]        tag;
        logic signed [OUT_W-1:0] prod;
    } t_tok;

endpackage

>>> rtl/core/mm8_ram.sv
module mm8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/mm8_cell.sv
module mm8_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [mm8_pkg::IDX_W-1:0]        i_idx,
    input  mm8_pkg::t_tok                    i_tok,
    output mm8_pkg::t_tok                    o_tok,
    input  logic                             i_shift,
    input  logic signed [mm8_pkg::OUT_W-1:0] i_acc,
    output logic signed [mm8_pkg::OUT_W-1:0] o_acc
);

    logic signed [mm8_pkg::OUT_W-1:0] r_acc;
    mm8_pkg::t_tok                    r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
            if (i_shift) begin
                // hand the finished sum toward the output end
                r_acc <= i_acc;
            end else if (i_tok.vld && i_tok.tag == i_idx) begin
                r_acc <= r_acc + i_tok.prod;
            end
        end
        r_tok.tag  <= i_tok.tag;
        r_tok.prod <= i_tok.prod;
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

>>> rtl/core/matrix_multiply_8x8.sv
// 8x8 matrix product C = A x B on signed 16-bit fixed-point elements.
// Each input item writes A[row][col] and B[row][col]; both stores read as
// zero after reset and keep their contents until overwritten. An item with
// last set writes its elements and then starts the product: one shared
// multiplier forms A[i][k]*B[k][j] per cycle, and the products run down a
// chain of DIM accumulator cells, where cell j collects C[i][j]. Each row
// takes DIM*DIM products, then a wait while the chain flushes, then its DIM
// results shift out of the chain, one item per cycle while the output is
// taken. Items that are not last only load the stores. No input item is
// taken while a product is running. Results leave in row-major order with
// an exact 35-bit sum, and out_last marks the final element of C.
module matrix_multiply_8x8 (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [mm8_pkg::ROW_W-1:0]             i_row,
    input  logic [mm8_pkg::ROW_W-1:0]             i_col,
    input  logic signed [mm8_pkg::ELEM_WIDTH-1:0] i_a_value,
    input  logic signed [mm8_pkg::ELEM_WIDTH-1:0] i_b_value,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [mm8_pkg::ROW_W-1:0]             o_out_row,
    output logic [mm8_pkg::ROW_W-1:0]             o_out_col,
    output logic signed [mm8_pkg::OUT_W-1:0]      o_product_value,
    output logic                                  o_out_last
);

    localparam int IW    = mm8_pkg::IDX_W;
    localparam int AW    = mm8_pkg::ADDR_W;
    localparam int EW    = mm8_pkg::ELEM_WIDTH;
    localparam int OW    = mm8_pkg::OUT_W;
    localparam int NCELL = mm8_pkg::DIM;
    localparam int NWAIT = mm8_pkg::DIM + 3;
    localparam int WW    = $clog2(NWAIT + 1);
    localparam logic [IW-1:0] IMAX = IW'(mm8_pkg::DIM - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_DRAIN} t_state;

    t_state          r_st;
    logic [IW-1:0]   r_row, r_k, r_j, r_drain;
    logic [WW-1:0]   r_wait;

    // input side: store writes and per-entry valid bits
    logic            in_acc, in_range, in_we;
    logic [AW-1:0]   wr_addr, a_raddr, b_raddr;
    logic            r_vld [mm8_pkg::DIM * mm8_pkg::DIM];
    logic            r_a_ok, r_b_ok;
    logic [EW-1:0]   a_rdata, b_rdata;

    assign o_ready  = (r_st == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign in_range = (int'(i_row) < mm8_pkg::DIM) && (int'(i_col) < mm8_pkg::DIM);
    assign in_we    = in_acc && in_range;
    assign wr_addr  = AW'(IW'(i_row)) * AW'(mm8_pkg::DIM) + AW'(IW'(i_col));
    assign a_raddr  = AW'(r_row) * AW'(mm8_pkg::DIM) + AW'(r_k);
    assign b_raddr  = AW'(r_k) * AW'(mm8_pkg::DIM) + AW'(r_j);

    mm8_ram #(.WIDTH(EW), .DEPTH(mm8_pkg::DIM * mm8_pkg::DIM)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (wr_addr),
        .i_wdata (i_a_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mm8_ram #(.WIDTH(EW), .DEPTH(mm8_pkg::DIM * mm8_pkg::DIM)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (wr_addr),
        .i_wdata (i_b_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < mm8_pkg::DIM * mm8_pkg::DIM; e++) begin
                r_vld[e] <= 1'b0;
            end
        end else if (in_we) begin
            r_vld[wr_addr] <= 1'b1;
        end
        r_a_ok <= r_vld[a_raddr];
        r_b_ok <= r_vld[b_raddr];
    end

    // multiply stage: read issue -> operands -> registered product
    logic                   r_iss_vld, r_mul_vld;
    logic [IW-1:0]          r_iss_tag, r_mul_tag;
    logic signed [EW-1:0]   a_op, b_op;
    logic signed [2*EW-1:0] mul;
    logic signed [OW-1:0]   r_prod;
    mm8_pkg::t_tok          tok0;

    assign a_op = r_a_ok ? signed'(a_rdata) : '0;
    assign b_op = r_b_ok ? signed'(b_rdata) : '0;
    assign mul  = a_op * b_op;

    logic signed [mm8_pkg::EXT_W-1:0] mul_ext;
    assign mul_ext = mm8_pkg::EXT_W'(mul);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_vld <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_iss_vld <= (r_st == S_RUN);
            r_mul_vld <= r_iss_vld;
        end
        r_iss_tag <= r_j;
        r_mul_tag <= r_iss_tag;
        r_prod    <= mul_ext[OW-1:0];
    end

    assign tok0.vld  = r_mul_vld;
    assign tok0.tag  = r_mul_tag;
    assign tok0.prod = r_prod;

    // chain of accumulator cells; cell j sums column j of the current row
    mm8_pkg::t_tok        tok [NCELL + 1];
    logic signed [OW-1:0] acc [NCELL + 1];
    logic                 shift;

    assign tok[0]     = tok0;
    assign acc[NCELL] = '0;
    assign shift      = (r_st == S_DRAIN) && (!o_valid || i_ready);

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        mm8_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IW'(g)),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_shift (shift),
            .i_acc   (acc[g+1]),
            .o_acc   (acc[g])
        );
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_row   <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_drain <= '0;
            r_wait  <= '0;
            o_valid <= 1'b0;
        end else begin
            // a shift reloads the output register below
            if (o_valid && i_ready && !shift) begin
                o_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_acc && i_last) begin
                        r_st  <= S_RUN;
                        r_row <= '0;
                        r_k   <= '0;
                        r_j   <= '0;
                    end
                end
                S_RUN: begin
                    // j inner, k outer: one product per cycle
                    if (r_j == IMAX) begin
                        r_j <= '0;
                        if (r_k == IMAX) begin
                            r_k    <= '0;
                            r_wait <= '0;
                            r_st   <= S_WAIT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_WAIT: begin
                    // let the last products reach the far end of the chain
                    if (r_wait == WW'(NWAIT - 1)) begin
                        r_drain <= '0;
                        r_st    <= S_DRAIN;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (shift) begin
                        o_valid         <= 1'b1;
                        o_out_row       <= mm8_pkg::ROW_W'(r_row);
                        o_out_col       <= mm8_pkg::ROW_W'(r_drain);
                        o_product_value <= acc[0];
                        o_out_last      <= (r_row == IMAX) && (r_drain == IMAX);
                        if (r_drain == IMAX) begin
                            if (r_row == IMAX) begin
                                r_st <= S_IDLE;
                            end else begin
                                r_row <= r_row + 1'b1;
                                r_st  <= S_RUN;
                            end
                        end else begin
                            r_drain <= r_drain + 1'b1;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last |=> r_st == S_RUN)
        else $error("last item did not start the product");

    a_final_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> o_out_row == mm8_pkg::ROW_W'(IMAX)
                                && o_out_col == mm8_pkg::ROW_W'(IMAX))
        else $error("final item flagged at wrong index");

    a_no_tok_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_DRAIN |-> !tok0.vld)
        else $error("product entered chain during drain");
`endif

endmodule
